### sv/lrc_pkg.sv
`default_nettype none
package lrc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = 4;
  localparam int CTRY_W  = 16;
  localparam int CITY_W  = 32;
  localparam int POP_W   = 32;
  localparam int CNT_W   = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } lrc_cmd_t;

  // Scan token handed from cell to cell. It carries the running victim
  // search of an insert.
  typedef struct packed {
    logic              active;
    lrc_cmd_t          cmd;
    logic              have_empty;
    logic              have_best;
    logic [IDX_W-1:0]  best_idx;
    logic [CNT_W-1:0]  best_cnt;
    logic [CNT_W-1:0]  best_age;
  } lrc_tok_t;

  // Match reported by a cell; all zero when there is none.
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [CTRY_W-1:0] country;
    logic [CITY_W-1:0] city;
    logic [POP_W-1:0]  pop;
    logic [CNT_W-1:0]  cnt;
  } lrc_hit_t;

  // Entry write broadcast to every cell at the end of an insert.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [CTRY_W-1:0] country;
    logic [CITY_W-1:0] city;
    logic [POP_W-1:0]  pop;
  } lrc_wr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : CNT_W'(v + CNT_ONE);
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### sv/lrc_cell.sv
`default_nettype none
module lrc_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [lrc_pkg::IDX_W-1:0]  cell_idx,
  input  wire logic                      advance,
  input  wire logic [lrc_pkg::CTRY_W-1:0] q_country,
  input  wire logic [lrc_pkg::CITY_W-1:0] q_city,
  input  wire lrc_pkg::lrc_wr_t           wr,
  input  wire lrc_pkg::lrc_tok_t          tok_in,
  output lrc_pkg::lrc_tok_t               tok_out,
  output lrc_pkg::lrc_hit_t               hit
);

  logic                      valid_r, valid_nxt;
  logic [lrc_pkg::CTRY_W-1:0] country_r, country_nxt;
  logic [lrc_pkg::CITY_W-1:0] city_r, city_nxt;
  logic [lrc_pkg::POP_W-1:0]  pop_r, pop_nxt;
  logic [lrc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [lrc_pkg::CNT_W-1:0]  age_r, age_nxt;
  lrc_pkg::lrc_tok_t          tok_r, tok_nxt;

  logic here, lookup, match, take;

  assign here   = tok_in.active && advance;
  assign lookup = tok_in.cmd == lrc_pkg::CMD_LOOKUP;
  assign match  = valid_r && (country_r == q_country) && (city_r == q_city);

  // An occupied entry replaces the running candidate when it has fewer uses,
  // or as many uses and more age. Earlier slots win exact ties.
  assign take = !tok_in.have_best || (cnt_r < tok_in.best_cnt) ||
                ((cnt_r == tok_in.best_cnt) && (age_r > tok_in.best_age));

  always_comb begin
    valid_nxt   = valid_r;
    country_nxt = country_r;
    city_nxt    = city_r;
    pop_nxt     = pop_r;
    cnt_nxt     = cnt_r;
    age_nxt     = age_r;
    tok_nxt     = tok_in;
    hit         = '0;
    if (wr.en && (wr.idx == cell_idx)) begin
      valid_nxt   = 1'b1;
      country_nxt = wr.country;
      city_nxt    = wr.city;
      pop_nxt     = wr.pop;
      cnt_nxt     = lrc_pkg::CNT_ONE;
      age_nxt     = lrc_pkg::CNT_ONE;
    end else if (tok_in.active && lookup) begin
      // The hit is shown while the token waits here; the entry itself only
      // changes in the cycle the row advances.
      if (here && valid_r) begin
        age_nxt = lrc_pkg::sat_inc(age_r);
      end
      if (match) begin
        if (here) begin
          cnt_nxt = lrc_pkg::sat_inc(cnt_r);
        end
        hit.vld     = 1'b1;
        hit.idx     = cell_idx;
        hit.country = country_r;
        hit.city    = city_r;
        hit.pop     = pop_r;
        hit.cnt     = lrc_pkg::sat_inc(cnt_r);
      end
    end else if (here) begin
      if (!tok_in.have_empty) begin
        if (!valid_r) begin
          tok_nxt.have_empty = 1'b1;
          tok_nxt.best_idx   = cell_idx;
        end else if (take) begin
          tok_nxt.have_best = 1'b1;
          tok_nxt.best_idx  = cell_idx;
          tok_nxt.best_cnt  = cnt_r;
          tok_nxt.best_age  = age_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (advance) begin
        tok_r <= tok_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    country_r <= country_nxt;
    city_r    <= city_nxt;
    pop_r     <= pop_nxt;
    cnt_r     <= cnt_nxt;
    age_r     <= age_nxt;
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

### sv/lfu_record_cache.sv
`default_nettype none
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+----------------------------------------
// in_      | input     | in_valid / in_ready  | command, country code, city tag, population
// out_     | output    | out_valid / out_ready| found, slot, country, city, population,
//          |           |                      | hit count, last
//
// One transaction at a time: a scan token walks the row of entry cells, one per cycle while
// the row is not frozen, and in_ready rises again once the closing result is registered.
// A match that finds the pending result full freezes the whole row for every cycle in
// which the output register still holds an untaken result; the closing result waits
// for that register the same way.
// Reset clears every valid mark and all control state; entry data is not reset.
module lfu_record_cache (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [0:0]                 in_command,
  input  wire logic [lrc_pkg::CTRY_W-1:0] in_country_code,
  input  wire logic [lrc_pkg::CITY_W-1:0] in_city_tag,
  input  wire logic [lrc_pkg::POP_W-1:0]  in_population,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_found,
  output logic [lrc_pkg::SLOT_W-1:0]      out_slot,
  output logic [lrc_pkg::CTRY_W-1:0]      out_country,
  output logic [lrc_pkg::CITY_W-1:0]      out_city,
  output logic [lrc_pkg::POP_W-1:0]       out_population,
  output logic [lrc_pkg::CNT_W-1:0]       out_hit_count,
  output logic                            out_last
);

  // Query registers, held for the whole scan and broadcast to every cell.
  logic                       busy_r, busy_nxt;
  logic                       head_r, head_nxt;
  lrc_pkg::lrc_cmd_t          cmd_r;
  logic [lrc_pkg::CTRY_W-1:0] country_r;
  logic [lrc_pkg::CITY_W-1:0] city_r;
  logic [lrc_pkg::POP_W-1:0]  pop_r;

  // A lookup's hits are held back one place, so that the last one can be
  // flagged once the scan has passed the final cell.
  logic              pend_v_r, pend_v_nxt;
  lrc_pkg::lrc_hit_t pend_r, pend_nxt;

  logic                       out_v_r, out_v_nxt;
  logic                       found_r, found_nxt;
  logic [lrc_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [lrc_pkg::CTRY_W-1:0] octry_r, octry_nxt;
  logic [lrc_pkg::CITY_W-1:0] ocity_r, ocity_nxt;
  logic [lrc_pkg::POP_W-1:0]  opop_r, opop_nxt;
  logic [lrc_pkg::CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic                       last_r, last_nxt;

  lrc_pkg::lrc_tok_t tok_chain [lrc_pkg::ENTRIES+1];
  lrc_pkg::lrc_hit_t hits [lrc_pkg::ENTRIES];
  lrc_pkg::lrc_hit_t hit_any;
  lrc_pkg::lrc_tok_t tail;
  lrc_pkg::lrc_wr_t  wr;

  logic accept, out_busy, stall, advance, fin, shift_pend;

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign out_busy = out_v_r && !out_ready;
  assign tail     = tok_chain[lrc_pkg::ENTRIES];

  // Only one cell holds the token, so at most one hit is nonzero.
  always_comb begin
    hit_any = '0;
    for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
      hit_any = lrc_pkg::lrc_hit_t'(hit_any | hits[i]);
    end
  end

  // A hit while the pending slot is full must push the pending result out;
  // the final result likewise needs the output register.
  assign stall      = (hit_any.vld && pend_v_r && out_busy) || (tail.active && out_busy);
  assign advance    = !stall;
  assign fin        = tail.active && !out_busy;
  assign shift_pend = hit_any.vld && pend_v_r && advance;

  always_comb begin
    tok_chain[0]            = '0;
    tok_chain[0].active     = head_r;
    tok_chain[0].cmd        = cmd_r;
  end

  for (genvar g = 0; g < lrc_pkg::ENTRIES; g++) begin : g_cell
    lrc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (lrc_pkg::IDX_W'(g)),
      .advance   (advance),
      .q_country (country_r),
      .q_city    (city_r),
      .wr        (wr),
      .tok_in    (tok_chain[g]),
      .tok_out   (tok_chain[g+1]),
      .hit       (hits[g])
    );
  end

  // The insert lands in the chosen slot as its acknowledge leaves.
  always_comb begin
    wr         = '0;
    wr.en      = fin && (tail.cmd == lrc_pkg::CMD_INSERT);
    wr.idx     = tail.best_idx;
    wr.country = country_r;
    wr.city    = city_r;
    wr.pop     = pop_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    head_nxt = head_r;
    if (accept) begin
      busy_nxt = 1'b1;
      head_nxt = 1'b1;
    end else begin
      if (advance) begin
        head_nxt = 1'b0;
      end
      if (fin) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (hit_any.vld && advance) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = hit_any;
    end else if (fin) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r && !out_ready;
    found_nxt = found_r;
    slot_nxt  = slot_r;
    octry_nxt = octry_r;
    ocity_nxt = ocity_r;
    opop_nxt  = opop_r;
    ocnt_nxt  = ocnt_r;
    last_nxt  = last_r;
    priority if (fin && pend_v_r) begin
      out_v_nxt = 1'b1;
      found_nxt = 1'b1;
      slot_nxt  = lrc_pkg::to_slot(pend_r.idx);
      octry_nxt = pend_r.country;
      ocity_nxt = pend_r.city;
      opop_nxt  = pend_r.pop;
      ocnt_nxt  = pend_r.cnt;
      last_nxt  = 1'b1;
    end else if (fin && (tail.cmd == lrc_pkg::CMD_INSERT)) begin
      out_v_nxt = 1'b1;
      found_nxt = 1'b0;
      slot_nxt  = lrc_pkg::to_slot(tail.best_idx);
      octry_nxt = country_r;
      ocity_nxt = city_r;
      opop_nxt  = pop_r;
      ocnt_nxt  = lrc_pkg::CNT_ONE;
      last_nxt  = 1'b1;
    end else if (fin) begin
      // Lookup without any match.
      out_v_nxt = 1'b1;
      found_nxt = 1'b0;
      slot_nxt  = '0;
      octry_nxt = '0;
      ocity_nxt = '0;
      opop_nxt  = '0;
      ocnt_nxt  = '0;
      last_nxt  = 1'b1;
    end else if (shift_pend) begin
      out_v_nxt = 1'b1;
      found_nxt = 1'b1;
      slot_nxt  = lrc_pkg::to_slot(pend_r.idx);
      octry_nxt = pend_r.country;
      ocity_nxt = pend_r.city;
      opop_nxt  = pend_r.pop;
      ocnt_nxt  = pend_r.cnt;
      last_nxt  = 1'b0;
    end else begin
      out_v_nxt = out_v_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      head_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      head_r   <= head_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= lrc_pkg::lrc_cmd_t'(in_command);
      country_r <= in_country_code;
      city_r    <= in_city_tag;
      pop_r     <= in_population;
    end
    pend_r  <= pend_nxt;
    found_r <= found_nxt;
    slot_r  <= slot_nxt;
    octry_r <= octry_nxt;
    ocity_r <= ocity_nxt;
    opop_r  <= opop_nxt;
    ocnt_r  <= ocnt_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_found      = found_r;
  assign out_slot       = slot_r;
  assign out_country    = octry_r;
  assign out_city       = ocity_r;
  assign out_population = opop_r;
  assign out_hit_count  = ocnt_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

### tb/lrc_checker.sv
`timescale 1ns / 100ps
module lrc_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic [0:0]                 in_command,
  input  wire logic [lrc_pkg::CTRY_W-1:0] in_country_code,
  input  wire logic [lrc_pkg::CITY_W-1:0] in_city_tag,
  input  wire logic [lrc_pkg::POP_W-1:0]  in_population,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic                       out_found,
  input  wire logic [lrc_pkg::SLOT_W-1:0] out_slot,
  input  wire logic [lrc_pkg::CTRY_W-1:0] out_country,
  input  wire logic [lrc_pkg::CITY_W-1:0] out_city,
  input  wire logic [lrc_pkg::POP_W-1:0]  out_population,
  input  wire logic [lrc_pkg::CNT_W-1:0]  out_hit_count,
  input  wire logic                       out_last,
  output int                              fail_count,
  output int                              outstanding
);

  typedef struct packed {
    logic                       found;
    logic [lrc_pkg::SLOT_W-1:0] slot;
    logic [lrc_pkg::CTRY_W-1:0] country;
    logic [lrc_pkg::CITY_W-1:0] city;
    logic [lrc_pkg::POP_W-1:0]  pop;
    logic [lrc_pkg::CNT_W-1:0]  cnt;
    logic                       last;
  } cache_result_t;

  // Shadow copy of the cache contents.
  logic                       shadow_valid   [lrc_pkg::ENTRIES];
  logic [lrc_pkg::CTRY_W-1:0] shadow_country [lrc_pkg::ENTRIES];
  logic [lrc_pkg::CITY_W-1:0] shadow_city    [lrc_pkg::ENTRIES];
  logic [lrc_pkg::POP_W-1:0]  shadow_pop     [lrc_pkg::ENTRIES];
  logic [lrc_pkg::CNT_W-1:0]  shadow_count   [lrc_pkg::ENTRIES];
  logic [lrc_pkg::CNT_W-1:0]  shadow_age     [lrc_pkg::ENTRIES];

  cache_result_t expected_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    for (int i = 0; i < lrc_pkg::ENTRIES; i++) shadow_valid[i] = 1'b0;
  end

  function automatic logic [lrc_pkg::CNT_W-1:0] bump(input logic [lrc_pkg::CNT_W-1:0] v);
    return (v == lrc_pkg::CNT_MAX) ? v : v + lrc_pkg::CNT_W'(1);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < 40)
      $display("ERROR: %0t ns %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic predict_cache(input lrc_pkg::lrc_cmd_t cmd,
                               input logic [lrc_pkg::CTRY_W-1:0] ctry,
                               input logic [lrc_pkg::CITY_W-1:0] city,
                               input logic [lrc_pkg::POP_W-1:0] pop);
    cache_result_t r;
    int victim;
    int hits;
    hits = 0;
    if (cmd == lrc_pkg::CMD_LOOKUP) begin
      for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
        if (shadow_valid[i]) begin
          if (shadow_country[i] == ctry && shadow_city[i] == city) begin
            shadow_count[i] = bump(shadow_count[i]);
            r.found   = 1'b1;
            r.slot    = lrc_pkg::SLOT_W'(i);
            r.country = shadow_country[i];
            r.city    = shadow_city[i];
            r.pop     = shadow_pop[i];
            r.cnt     = shadow_count[i];
            r.last    = 1'b0;
            expected_results.insert(expected_results.size(), r);
            hits++;
          end
          shadow_age[i] = bump(shadow_age[i]);
        end
      end
      if (hits == 0) begin
        r = '0;
        r.last = 1'b1;
        expected_results.insert(expected_results.size(), r);
      end else begin
        expected_results[expected_results.size()-1].last = 1'b1;
      end
    end else begin
      victim = -1;
      for (int i = 0; i < lrc_pkg::ENTRIES; i++)
        if (victim < 0 && !shadow_valid[i]) victim = i;
      if (victim < 0) begin
        victim = 0;
        for (int i = 1; i < lrc_pkg::ENTRIES; i++)
          if (shadow_count[i] < shadow_count[victim] ||
              (shadow_count[i] == shadow_count[victim] &&
               shadow_age[i] > shadow_age[victim]))
            victim = i;
      end
      shadow_valid[victim]   = 1'b1;
      shadow_country[victim] = ctry;
      shadow_city[victim]    = city;
      shadow_pop[victim]     = pop;
      shadow_count[victim]   = lrc_pkg::CNT_W'(1);
      shadow_age[victim]     = lrc_pkg::CNT_W'(1);
      r.found   = 1'b0;
      r.slot    = lrc_pkg::SLOT_W'(victim);
      r.country = ctry;
      r.city    = city;
      r.pop     = pop;
      r.cnt     = lrc_pkg::CNT_W'(1);
      r.last    = 1'b1;
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (rst_n) begin
      // Results belong to earlier transactions, so they are checked first.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, slot", 64'(out_slot), 64'(0));
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found)
            report_mismatch("found", 64'(out_found), 64'(want.found));
          if (out_slot !== want.slot)
            report_mismatch("slot", 64'(out_slot), 64'(want.slot));
          if (out_country !== want.country)
            report_mismatch("country", 64'(out_country), 64'(want.country));
          if (out_city !== want.city)
            report_mismatch("city", 64'(out_city), 64'(want.city));
          if (out_population !== want.pop)
            report_mismatch("population", 64'(out_population), 64'(want.pop));
          if (out_hit_count !== want.cnt)
            report_mismatch("hit count", 64'(out_hit_count), 64'(want.cnt));
          if (out_last !== want.last)
            report_mismatch("last", 64'(out_last), 64'(want.last));
        end
      end
      if (in_valid && in_ready)
        predict_cache(lrc_pkg::lrc_cmd_t'(in_command), in_country_code, in_city_tag,
                      in_population);
    end
    outstanding = expected_results.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  localparam int RANDOM_ITEMS = 250;
  // Range of random items during which neither side idles.
  localparam int CALM_FIRST   = 90;
  localparam int CALM_LAST    = 160;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_ready;
  logic [0:0]                 in_command      = '0;
  logic [lrc_pkg::CTRY_W-1:0] in_country_code = '0;
  logic [lrc_pkg::CITY_W-1:0] in_city_tag     = '0;
  logic [lrc_pkg::POP_W-1:0]  in_population   = '0;
  logic                       out_valid;
  logic                       out_ready       = 1'b0;
  logic                       out_found;
  logic [lrc_pkg::SLOT_W-1:0] out_slot;
  logic [lrc_pkg::CTRY_W-1:0] out_country;
  logic [lrc_pkg::CITY_W-1:0] out_city;
  logic [lrc_pkg::POP_W-1:0]  out_population;
  logic [lrc_pkg::CNT_W-1:0]  out_hit_count;
  logic                       out_last;

  int fail_count;
  int outstanding;

  // When set, the sender and the receiver both run without gaps.
  logic calm = 1'b0;

  // Keys of recent inserts, so that lookups hit and inserts make duplicates.
  logic [lrc_pkg::CTRY_W-1:0] known_country[$];
  logic [lrc_pkg::CITY_W-1:0] known_city[$];

  always #5 clk = ~clk;

  lfu_record_cache dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_country_code (in_country_code),
    .in_city_tag     (in_city_tag),
    .in_population   (in_population),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_slot        (out_slot),
    .out_country     (out_country),
    .out_city        (out_city),
    .out_population  (out_population),
    .out_hit_count   (out_hit_count),
    .out_last        (out_last)
  );

  lrc_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_country_code (in_country_code),
    .in_city_tag     (in_city_tag),
    .in_population   (in_population),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_slot        (out_slot),
    .out_country     (out_country),
    .out_city        (out_city),
    .out_population  (out_population),
    .out_hit_count   (out_hit_count),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // The receiver stalls about a third of the time, except in the calm stretch.
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
  end

  // Present one transaction and hold it until it is accepted. The task is entered
  // and left at a falling edge; the valid line is only lowered when the sender
  // decides to idle, so back-to-back items keep it high.
  task automatic send_item(input lrc_pkg::lrc_cmd_t cmd,
                           input logic [lrc_pkg::CTRY_W-1:0] ctry,
                           input logic [lrc_pkg::CITY_W-1:0] city,
                           input logic [lrc_pkg::POP_W-1:0] pop);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_country_code <= ctry;
    in_city_tag     <= city;
    in_population   <= pop;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (cmd == lrc_pkg::CMD_INSERT) begin
      known_country.insert(known_country.size(), ctry);
      known_city.insert(known_city.size(), city);
      if (known_country.size() > 24) begin
        void'(known_country.pop_front());
        void'(known_city.pop_front());
      end
    end
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Choose a key: known_pct percent of the time one that was inserted recently or a near miss
  // of one, sometimes from a tiny key space that collides often, else anything.
  task automatic pick_key(input int known_pct, output logic [lrc_pkg::CTRY_W-1:0] ctry,
                          output logic [lrc_pkg::CITY_W-1:0] city);
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    if (known_country.size() != 0 && roll < known_pct) begin
      k    = $urandom_range(0, known_country.size() - 1);
      ctry = known_country[k];
      city = known_city[k];
      case ($urandom_range(0, 9))
        0: city = city ^ (lrc_pkg::CITY_W'(1) << $urandom_range(0, lrc_pkg::CITY_W - 1));
        1: ctry = ctry ^ (lrc_pkg::CTRY_W'(1) << $urandom_range(0, lrc_pkg::CTRY_W - 1));
        default: ;
      endcase
    end else if (roll < known_pct + 20) begin
      ctry = {8'h41 + 8'($urandom_range(0, 2)), 8'h41 + 8'($urandom_range(0, 2))};
      city = lrc_pkg::CITY_W'($urandom_range(0, 7));
    end else begin
      ctry = lrc_pkg::CTRY_W'($urandom);
      city = $urandom;
    end
  endtask

  initial begin
    logic [lrc_pkg::CTRY_W-1:0] ctry;
    logic [lrc_pkg::CITY_W-1:0] city;
    int insert_pct;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Lookups on an empty cache miss.
    send_item(lrc_pkg::CMD_LOOKUP, '0, '0, '0);
    send_item(lrc_pkg::CMD_LOOKUP, '1, '1, '0);
    // Records at both extremes of every field, then hits on each of them.
    send_item(lrc_pkg::CMD_INSERT, '0, '0, '0);
    send_item(lrc_pkg::CMD_INSERT, '1, '1, '1);
    send_item(lrc_pkg::CMD_LOOKUP, '0, '0, '0);
    send_item(lrc_pkg::CMD_LOOKUP, '1, '1, '0);
    // A duplicate record takes a slot of its own, and a lookup returns both.
    send_item(lrc_pkg::CMD_INSERT, '1, '1, 32'h1234_5678);
    send_item(lrc_pkg::CMD_LOOKUP, '1, '1, '0);
    // Only the country matches, which is still a miss.
    send_item(lrc_pkg::CMD_LOOKUP, '1, '0, '0);
    // Fill the remaining slots; the cache ends up full.
    for (int i = 3; i < lrc_pkg::ENTRIES; i++)
      send_item(lrc_pkg::CMD_INSERT, 16'h5553, lrc_pkg::CITY_W'(i),
                lrc_pkg::POP_W'(i * 1000));
    // Inserts into a full cache evict the least used, oldest entry.
    send_item(lrc_pkg::CMD_INSERT, 16'h4652, 32'hCAFE_0001, 32'h0000_FFFF);
    send_item(lrc_pkg::CMD_LOOKUP, 16'h5553, lrc_pkg::CITY_W'(3), '0);
    send_item(lrc_pkg::CMD_INSERT, 16'h4652, 32'hCAFE_0002, 32'hFFFF_0000);
    wait_for_drain();

    // Random part: insert-heavy first to churn the slots, then lookup-heavy so
    // that use counts spread apart and eviction order depends on them.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= CALM_FIRST && n < CALM_LAST);
      if (n == CALM_FIRST || n == 200) wait_for_drain();
      insert_pct = (n < CALM_FIRST) ? 50 : 30;
      if ($urandom_range(0, 99) < insert_pct) begin
        pick_key(30, ctry, city);
        send_item(lrc_pkg::CMD_INSERT, ctry, city, $urandom);
      end else begin
        pick_key(75, ctry, city);
        send_item(lrc_pkg::CMD_LOOKUP, ctry, city, $urandom);
      end
    end

    wait_for_drain();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
sv/lrc_pkg.sv
sv/lrc_cell.sv
sv/lfu_record_cache.sv
tb/lrc_checker.sv
tb/tb_top.sv
